// ----- design/cq_pkg.sv -----
// Shared types and constants for the circular word queue.
// Used by cq_ctrl, cq_out_buf and circular_queue; no dependencies.
`default_nettype none

package cq_pkg;

   // Fixed field widths.
   localparam int WORD_W   = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 7;

   // Default number of slots.
   localparam int DEPTH_DEF = 64;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DISP = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

   // One response beat.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   word;
      logic                last;
   } rsp_beat_type;

   // Occupancy of the response buffer as seen by the controller.
   typedef struct packed {
      logic [1:0] cnt;
      logic       pop;
   } buf_status_type;

endpackage

`default_nettype wire

// ----- design/circular_queue.sv -----
// Top level of the circular word queue: controller, slot RAM and response
// buffer. Depends on cq_pkg, cq_ctrl, cq_ram and cq_out_buf.
//
//   Channel   Direction  Handshake              Beat contents
//   req_*     in         req_tvalid/req_tready  tuser: action, tdata: push value
//   rsp_*     out        rsp_tvalid/rsp_tready  tuser: status, tdata: word, tlast
//   csr_*     in         csr_wr_en              capacity (empties the queue)
//
// Enqueue, dequeue and the error cases run at one request per cycle while
// responses drain. A display of N words streams one word per cycle from the
// slot RAM read port while responses drain, occupying the controller until
// the last is issued. Responses pass the result stage, then the out buffer.
// On a stalled response channel req_tready drops once the result stage and the
// two-entry response buffer hold two beats between them; the buffer then fills.
// Reset empties the queue and sets the capacity to DEPTH.
`default_nettype none

module circular_queue #(
   parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [cq_pkg::CAP_W-1:0]      csr_wr_data,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [cq_pkg::WORD_W-1:0]     req_tdata,  // [31:0] push_value
   input  wire logic [cq_pkg::ACTION_W-1:0]   req_tuser,  // [1:0] action
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [cq_pkg::WORD_W-1:0]          rsp_tdata,  // [31:0] data_word
   output logic [cq_pkg::STATUS_W-1:0]        rsp_tuser,  // [1:0] status
   output logic                               rsp_tlast
);

   localparam int AW = $clog2(DEPTH);

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [cq_pkg::WORD_W-1:0]     ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [cq_pkg::WORD_W-1:0]     ram_rd_data;
   cq_pkg::buf_status_type        buf_status;
   logic                          push;
   cq_pkg::rsp_beat_type          push_beat;
   cq_pkg::rsp_beat_type          out_beat;

   // Pointer and sequencing logic.
   cq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tuser),
      .req_value   (req_tdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .buf_status  (buf_status),
      .push        (push),
      .push_beat   (push_beat)
   );

   // Slot storage.
   cq_ram #(
      .WIDTH(cq_pkg::WORD_W),
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response buffer.
   cq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_beat  (out_beat),
      .status    (buf_status)
   );

   assign rsp_tdata = out_beat.word;
   assign rsp_tuser = out_beat.status;
   assign rsp_tlast = out_beat.last;

endmodule

`default_nettype wire

// ----- design/cq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module cq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/cq_out_buf.sv -----
// Two-entry response buffer that decouples the controller from the stall
// of the response channel. Depends on cq_pkg.
`default_nettype none

module cq_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cq_pkg::rsp_beat_type  push_beat,
   input  wire logic                  out_ready,
   output logic                       out_valid,
   output cq_pkg::rsp_beat_type       out_beat,
   output cq_pkg::buf_status_type     status
);

   cq_pkg::rsp_beat_type ent_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_beat  = ent_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // The controller only pushes when a slot is free after this cycle's pop.
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_beat;
      end
   end

   assign status.cnt = cnt_ff;
   assign status.pop = pop;

endmodule

`default_nettype wire

// ----- design/cq_ctrl.sv -----
// Queue controller: pointers, occupancy, capacity, display sequencer and
// the result stage that merges RAM read data. Depends on cq_pkg.
`default_nettype none

module cq_ctrl #(
   parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [cq_pkg::CAP_W-1:0]      csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cq_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [cq_pkg::WORD_W-1:0]     req_value,
   output logic                               ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]           ram_wr_addr,
   output logic [cq_pkg::WORD_W-1:0]          ram_wr_data,
   output logic                               ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]           ram_rd_addr,
   input  wire logic [cq_pkg::WORD_W-1:0]     ram_rd_data,
   input  wire cq_pkg::buf_status_type        buf_status,
   output logic                               push,
   output cq_pkg::rsp_beat_type               push_beat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (AW + 1 > CW) ? AW + 1 : CW;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DISP = 1'b1;

   logic                          state_ff, state_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [AW-1:0]                 tail_ff, tail_in;
   logic [CW-1:0]                 occ_ff, occ_in;
   logic [CW-1:0]                 cap_ff, cap_in;
   logic [AW-1:0]                 disp_idx_ff, disp_idx_in;
   logic [CW-1:0]                 disp_left_ff, disp_left_in;
   logic                          stage_valid_ff, stage_valid_in;
   logic                          stage_ram_ff, stage_ram_in;
   logic                          stage_last_ff, stage_last_in;
   logic [cq_pkg::STATUS_W-1:0]   stage_status_ff, stage_status_in;
   logic [cq_pkg::WORD_W-1:0]     stage_word_ff, stage_word_in;
   logic [2:0]                    used;
   logic                          can_issue;
   logic                          accept;

   // Increment and wrap at the effective capacity.
   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] cap);
      logic [AW:0] n;
      begin
         n = {1'b0, idx} + {{AW{1'b0}}, 1'b1};
         if (XW'(n) >= XW'(cap)) begin
            wrap_next = '0;
         end else begin
            wrap_next = n[AW-1:0];
         end
      end
   endfunction

   // A new stage entry may start when the buffer will still have room for it.
   always_comb begin
      used      = {1'b0, buf_status.cnt} + {2'b00, stage_valid_ff};
      can_issue = (used < 3'd2) || ((used == 3'd2) && buf_status.pop);
   end

   assign req_ready = (state_ff == ST_IDLE) && can_issue;
   assign accept    = req_valid && req_ready;

   // Request decoding, pointer updates and display sequencing.
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      occ_in          = occ_ff;
      cap_in          = cap_ff;
      disp_idx_in     = disp_idx_ff;
      disp_left_in    = disp_left_ff;
      stage_valid_in  = 1'b0;
      stage_ram_in    = 1'b0;
      stage_last_in   = 1'b1;
      stage_status_in = cq_pkg::STAT_OK;
      stage_word_in   = '0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = tail_ff;
      ram_wr_data     = req_value;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  cq_pkg::ACT_ENQ: begin
                     stage_valid_in = 1'b1;
                     if (occ_ff >= cap_ff) begin
                        stage_status_in = cq_pkg::STAT_OVERFLOW;
                     end else begin
                        ram_wr_en     = 1'b1;
                        tail_in       = wrap_next(tail_ff, cap_ff);
                        occ_in        = occ_ff + CW'(1);
                        stage_word_in = req_value;
                     end
                  end
                  cq_pkg::ACT_DEQ: begin
                     stage_valid_in = 1'b1;
                     if (occ_ff == '0) begin
                        stage_status_in = cq_pkg::STAT_UNDERFLOW;
                     end else begin
                        ram_rd_en    = 1'b1;
                        stage_ram_in = 1'b1;
                        head_in      = wrap_next(head_ff, cap_ff);
                        occ_in       = occ_ff - CW'(1);
                     end
                  end
                  cq_pkg::ACT_DISP: begin
                     stage_valid_in = 1'b1;
                     if (occ_ff == '0) begin
                        stage_status_in = cq_pkg::STAT_EMPTY;
                     end else begin
                        ram_rd_en     = 1'b1;
                        stage_ram_in  = 1'b1;
                        stage_last_in = (occ_ff == CW'(1));
                        disp_idx_in   = wrap_next(head_ff, cap_ff);
                        disp_left_in  = occ_ff - CW'(1);
                        if (occ_ff != CW'(1)) begin
                           state_in = ST_DISP;
                        end
                     end
                  end
                  default: begin
                     // Unused action code: no result, no change.
                  end
               endcase
            end
         end
         ST_DISP: begin
            if (can_issue) begin
               ram_rd_en      = 1'b1;
               ram_rd_addr    = disp_idx_ff;
               stage_valid_in = 1'b1;
               stage_ram_in   = 1'b1;
               stage_last_in  = (disp_left_ff == CW'(1));
               disp_idx_in    = wrap_next(disp_idx_ff, cap_ff);
               disp_left_in   = disp_left_ff - CW'(1);
               if (disp_left_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity write clamps the value and empties the queue.
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            cap_in = CW'(1);
         end else if (csr_wr_data > cq_pkg::CAP_W'(DEPTH)) begin
            cap_in = CW'(DEPTH);
         end else begin
            cap_in = CW'(csr_wr_data);
         end
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         occ_ff         <= '0;
         cap_ff         <= CW'(DEPTH);
         disp_idx_ff    <= '0;
         disp_left_ff   <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         occ_ff         <= occ_in;
         cap_ff         <= cap_in;
         disp_idx_ff    <= disp_idx_in;
         disp_left_ff   <= disp_left_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Stage payload needs no reset.
   always_ff @(posedge clock) begin
      stage_ram_ff    <= stage_ram_in;
      stage_last_ff   <= stage_last_in;
      stage_status_ff <= stage_status_in;
      stage_word_ff   <= stage_word_in;
   end

   // The stage lines up with the RAM read data in the cycle after issue.
   assign push             = stage_valid_ff;
   assign push_beat.status = stage_status_ff;
   assign push_beat.word   = stage_ram_ff ? ram_rd_data : stage_word_ff;
   assign push_beat.last   = stage_last_ff;

endmodule

`default_nettype wire

// ----- tb/circular_queue_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circular_queue: a directed table followed by random
// phases at several capacities, every beat checked against the table or a predictor.
// Depends on cq_pkg and the circular_queue design files.

module circular_queue_tb;
   import cq_pkg::*;

   localparam int          QUEUE_DEPTH  = 64;
   localparam int          RANDOM_ITEMS = 215;
   localparam int          QUIET_CYCLES = 8;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          CYCLE_LIMIT  = 2_000_000;
   localparam int          NUM_ROWS     = 30;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // One row of the directed table: either a capacity write or a request beat.
   typedef struct packed {
      logic                is_cfg;
      logic [ACTION_W-1:0] action;
      logic [WORD_W-1:0]   value;
      logic                typed;
      logic [STATUS_W-1:0] t_status;
      logic [WORD_W-1:0]   t_word;
   } plan_row_t;

   logic                clock;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [WORD_W-1:0]   req_tdata   = '0;
   logic [ACTION_W-1:0] req_tuser   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [WORD_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic                rsp_tlast;

   circular_queue #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // Shadow copy of the queue state.
   logic [WORD_W-1:0] slot_copy [QUEUE_DEPTH];
   logic [5:0]        head_ptr;
   logic [5:0]        tail_ptr;
   logic [CAP_W-1:0]  fill_level;
   logic [CAP_W-1:0]  capacity_reg;

   rsp_beat_type op_beats [$];
   rsp_beat_type awaited_beats [$];
   rsp_beat_type oldest_beat;
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           req_gaps_on = 1'b1;

   // The directed table; typed rows carry their single expected beat.
   plan_row_t directed_plan [NUM_ROWS] = '{
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b1, STAT_UNDERFLOW, 32'h0000_0000},
      '{1'b0, ACT_DISP,   32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
      '{1'b0, ACT_UNUSED, 32'hDEAD_BEEF, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_ENQ,    32'h8000_0000, 1'b1, STAT_OK,        32'h8000_0000},
      '{1'b0, ACT_ENQ,    32'h7FFF_FFFF, 1'b1, STAT_OK,        32'h7FFF_FFFF},
      '{1'b0, ACT_ENQ,    32'hFFFF_FFFF, 1'b1, STAT_OK,        32'hFFFF_FFFF},
      '{1'b0, ACT_ENQ,    32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DISP,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DISP,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b1, ACT_ENQ,    32'h0000_0001, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_ENQ,    32'h1234_5678, 1'b1, STAT_OK,        32'h1234_5678},
      '{1'b0, ACT_ENQ,    32'hA5A5_A5A5, 1'b1, STAT_OVERFLOW,  32'h0000_0000},
      '{1'b0, ACT_DISP,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b1, STAT_UNDERFLOW, 32'h0000_0000},
      '{1'b1, ACT_ENQ,    32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_ENQ,    32'h5555_5555, 1'b1, STAT_OK,        32'h5555_5555},
      '{1'b0, ACT_ENQ,    32'hAAAA_AAAA, 1'b1, STAT_OVERFLOW,  32'h0000_0000},
      '{1'b1, ACT_ENQ,    32'h0000_0002, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_ENQ,    32'h0000_0001, 1'b1, STAT_OK,        32'h0000_0001},
      '{1'b0, ACT_ENQ,    32'h0000_0002, 1'b1, STAT_OK,        32'h0000_0002},
      '{1'b0, ACT_ENQ,    32'h0000_0003, 1'b1, STAT_OVERFLOW,  32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_ENQ,    32'h0000_0004, 1'b1, STAT_OK,        32'h0000_0004},
      '{1'b0, ACT_DISP,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
      '{1'b0, ACT_DEQ,    32'h0000_0000, 1'b1, STAT_UNDERFLOW, 32'h0000_0000},
      '{1'b0, ACT_UNUSED, 32'h2152_4110, 1'b0, STAT_OK,        32'h0000_0000}
   };

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A capacity of zero behaves as one, anything above the depth as the depth.
   function automatic logic [CAP_W-1:0] active_capacity(input logic [CAP_W-1:0] cap);
      if (cap == 0)
         return CAP_W'(1);
      if (cap > QUEUE_DEPTH)
         return CAP_W'(QUEUE_DEPTH);
      return cap;
   endfunction

   // Pointers step by one and wrap at the active capacity.
   function automatic logic [5:0] ring_next(input logic [5:0] idx);
      logic [CAP_W-1:0] n;
      n = {1'b0, idx} + 1'b1;
      if (n >= active_capacity(capacity_reg))
         n = '0;
      return n[5:0];
   endfunction

   // Works out the beats a request produces and updates the shadow state.
   task automatic predict_queue_op(input logic [ACTION_W-1:0] action,
                                   input logic [WORD_W-1:0] value);
      logic [5:0] idx;
      int         i;
      op_beats.delete();
      case (action)
         ACT_ENQ: begin
            if (fill_level >= active_capacity(capacity_reg)) begin
               op_beats.push_back('{status: STAT_OVERFLOW, word: '0, last: 1'b1});
            end else begin
               slot_copy[tail_ptr] = value;
               tail_ptr = ring_next(tail_ptr);
               fill_level++;
               op_beats.push_back('{status: STAT_OK, word: value, last: 1'b1});
            end
         end
         ACT_DEQ: begin
            if (fill_level == 0) begin
               op_beats.push_back('{status: STAT_UNDERFLOW, word: '0, last: 1'b1});
            end else begin
               op_beats.push_back('{status: STAT_OK, word: slot_copy[head_ptr], last: 1'b1});
               head_ptr = ring_next(head_ptr);
               fill_level--;
            end
         end
         ACT_DISP: begin
            if (fill_level == 0) begin
               op_beats.push_back('{status: STAT_EMPTY, word: '0, last: 1'b1});
            end else begin
               idx = head_ptr;
               for (i = 0; i < fill_level; i++) begin
                  op_beats.push_back('{status: STAT_OK, word: slot_copy[idx],
                                       last: (i + 1 == fill_level)});
                  idx = ring_next(idx);
               end
            end
         end
         default: begin
            // The unused action code is swallowed without a response.
         end
      endcase
   endtask

   // Request-side idle gaps: mostly none or short, now and then long.
   function automatic int next_req_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_gaps_on || r < 50)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Presents one request beat, waits for it to be taken and records its beats.
   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic [WORD_W-1:0]   value,
                            input logic                typed,
                            input logic [STATUS_W-1:0] t_status,
                            input logic [WORD_W-1:0]   t_word);
      int gap;
      gap = next_req_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_queue_op(action, value);
      if (typed)
         awaited_beats.push_back('{status: t_status, word: t_word, last: 1'b1});
      else
         foreach (op_beats[k]) awaited_beats.push_back(op_beats[k]);
   endtask

   // Capacity writes happen only once the queue has answered everything.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_tvalid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_reg = cap;
      head_ptr     = '0;
      tail_ptr     = '0;
      fill_level   = '0;
   endtask

   // Extremes first, then random capacities.
   function automatic logic [CAP_W-1:0] phase_capacity(input int phase);
      case (phase)
         0:       return 7'd1;
         1:       return 7'd0;
         2:       return 7'd127;
         3:       return 7'd2;
         4:       return 7'd65;
         5:       return 7'd3;
         6:       return 7'd64;
         default: return CAP_W'($urandom_range(0, 127));
      endcase
   endfunction

   // Mostly runs in the current direction, with displays and stray codes mixed in.
   function automatic logic [ACTION_W-1:0] pick_action(input bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return ACT_UNUSED;
      if (r < 12)
         return ACT_DISP;
      if (r < 85)
         return filling ? ACT_ENQ : ACT_DEQ;
      return filling ? ACT_DEQ : ACT_ENQ;
   endfunction

   // Response-side back-pressure, switched off for stretches.
   int rsp_hold_left = 0;
   int rsp_mode_left = 0;
   bit rsp_stalls_on = 1'b1;
   always @(posedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         rsp_mode_left = $urandom_range(50, 300);
      end else begin
         rsp_mode_left--;
      end
      if (rsp_hold_left == 0) begin
         if (!rsp_stalls_on || $urandom_range(0, 1) == 0) begin
            rsp_tready    <= 1'b1;
            rsp_hold_left = $urandom_range(1, 12);
         end else begin
            rsp_tready    <= 1'b0;
            rsp_hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 3);
         end
      end else begin
         rsp_hold_left--;
      end
   end

   // Response checker: every accepted beat against the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_beats.size() == 0) begin
            $error("response beat with none awaited: status %0d word %h last %0b",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            oldest_beat = awaited_beats.pop_front();
            if (rsp_tuser !== oldest_beat.status) begin
               $error("status: expected %0d, got %0d", oldest_beat.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata !== oldest_beat.word) begin
               $error("data_word: expected %h, got %h", oldest_beat.word, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== oldest_beat.last) begin
               $error("last_of_run: expected %0b, got %0b", oldest_beat.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      int               row;
      int               phase;
      int               random_count;
      int               phase_len;
      int               run_left;
      int               i;
      bit               filling;
      logic [CAP_W-1:0] cap;
      logic [CAP_W-1:0] eff;
      logic [ACTION_W-1:0] act;

      repeat (5) @(posedge clock);
      reset        <= 1'b0;
      capacity_reg = CAP_W'(QUEUE_DEPTH);
      head_ptr     = '0;
      tail_ptr     = '0;
      fill_level   = '0;

      for (row = 0; row < NUM_ROWS; row++) begin
         if (directed_plan[row].is_cfg)
            write_capacity(directed_plan[row].value[CAP_W-1:0]);
         else
            send_item(directed_plan[row].action, directed_plan[row].value,
                      directed_plan[row].typed, directed_plan[row].t_status,
                      directed_plan[row].t_word);
      end

      // Random phases alternate fill and drain runs so full and empty are both hit.
      phase        = 0;
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         cap = phase_capacity(phase);
         write_capacity(cap);
         eff         = active_capacity(cap);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         phase_len   = 2 * eff + $urandom_range(8, 20);
         filling     = 1'b1;
         run_left    = $urandom_range(1, eff + 3);
         for (i = 0; i < phase_len && random_count < RANDOM_ITEMS; i++) begin
            if (run_left == 0) begin
               filling  = !filling;
               run_left = $urandom_range(1, eff + 3);
            end
            run_left--;
            act = pick_action(filling);
            send_item(act, $urandom(), 1'b0, STAT_OK, '0);
            if (act != ACT_UNUSED)
               random_count++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
